[rtl/lat_pkg.sv]
// Package for the lottery arbiter table: operation and status codes, FSM states
// and default sizes. No dependencies.
package lat_pkg;

  localparam int SLOTS_DEF     = 16;
  localparam int PRIO_BITS_DEF = 8;

  // Fixed port widths.
  localparam int FUNC_W   = 2;
  localparam int SLOT_W   = 4;
  localparam int PRIO_W   = 8;
  localparam int TICKET_W = 12;
  localparam int STATUS_W = 2;
  localparam int WINNER_W = 4;
  localparam int TOTAL_W  = 12;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_PICK   = 2'd2
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_BUSY  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_NOWIN = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_DONE
  } state_e;

endpackage

[rtl/lottery_arbiter_table.sv]
// Lottery arbiter table: slot weights in a synchronous memory, valid bits and
// the running total in flip-flops, and a sequencer that walks the table.
// Depends on lat_pkg.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_ready_o    func_i slot_i priority_req_i
//                                                  io_bound_i ticket_i
//   out      output     out_valid_o / out_ready_i  status_o winner_o total_out_o
//
// One item is in work at a time. For an add or a remove, the weight read is
// issued as the item is accepted, the sequencer executes the item in S_EXEC,
// and S_DONE loads the output register. A pick goes from S_EXEC into S_WALK,
// which reads one weight from the memory port per cycle over up to SLOTS
// slots. The next item can be accepted once the result has loaded.
// Reset clears all valid bits and the total at once; the weight memory needs
// no clearing, as only the weights of valid slots are used. A stalled output
// holds the finished item in the output register and a new item is accepted as
// soon as the sequencer is idle, but the next result waits for the register.
module lottery_arbiter_table
  import lat_pkg::*;
#(
  parameter int SLOTS         = SLOTS_DEF,
  parameter int PRIORITY_BITS = PRIO_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [SLOT_W-1:0]   slot_i,
  input  logic [PRIO_W-1:0]   priority_req_i,
  input  logic                io_bound_i,
  input  logic [TICKET_W-1:0] ticket_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [WINNER_W-1:0] winner_o,
  output logic [TOTAL_W-1:0]  total_out_o
);

  localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PB   = PRIORITY_BITS;
  // The sum of all weights stays below SLOTS * 2**PB.
  localparam int TW   = PB + SW;
  localparam int XW   = TW + TICKET_W;
  localparam logic [SW-1:0]     LAST      = SW'(SLOTS - 1);
  localparam logic [SW+SLOT_W-1:0] SLOTS_X = (SW + SLOT_W)'(SLOTS);
  localparam logic [XW-1:0]     TOTAL_MAX = XW'(4095);

  // Sequencer and table state.
  state_e            state_q, state_d;
  logic [SLOTS-1:0]  valid_q, valid_d;
  logic [TW-1:0]     total_q, total_d;
  logic [TW-1:0]     acc_q, acc_d;
  logic [SW-1:0]     idx_q, idx_d;
  status_e           res_status_q, res_status_d;
  logic [SW-1:0]     res_winner_q, res_winner_d;

  // Captured item.
  logic [FUNC_W-1:0]   func_q;
  logic [SW-1:0]       slot_q;
  logic                in_range_q;
  logic [PB-1:0]       w_q;
  logic [TICKET_W-1:0] ticket_q;

  // Weight memory.
  logic [PB-1:0] mem_q [SLOTS];
  logic [PB-1:0] rd_data_q;
  logic [SW-1:0] rd_addr;
  logic          mem_we;

  // Output register.
  logic                out_valid_q;
  status_e             status_q;
  logic [WINNER_W-1:0] winner_q;
  logic [TOTAL_W-1:0]  total_out_q;
  logic                out_free;
  logic                out_load;

  // Decode of the incoming item.
  logic [SW+SLOT_W-1:0] slot_ext;
  logic [SW-1:0]        in_idx;
  logic                 in_range;
  logic [PB+PRIO_W-1:0] prio_ext;
  logic [PB-1:0]        prio;
  logic [PB-1:0]        in_weight;
  logic                 in_accept;

  // Walk and output helpers.
  logic [TW-1:0]        acc_sum;
  logic [XW-1:0]        acc_x;
  logic [XW-1:0]        ticket_x;
  logic [XW-1:0]        total_x;
  logic [SW+WINNER_W-1:0] winner_x;
  logic                 hit;

  assign slot_ext  = {{SW{1'b0}}, slot_i};
  assign in_idx    = slot_ext[SW-1:0];
  assign in_range  = slot_ext < SLOTS_X;
  assign prio_ext  = {{PB{1'b0}}, priority_req_i};
  assign prio      = prio_ext[PB-1:0];
  assign in_weight = io_bound_i ? (prio >> 1) : prio;
  assign in_accept = in_valid_i && in_ready_o;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  assign acc_sum  = acc_q + TW'(rd_data_q);
  assign acc_x    = {{TICKET_W{1'b0}}, acc_sum};
  assign ticket_x = {{TW{1'b0}}, ticket_q};
  assign hit      = valid_q[idx_q] && (ticket_x < acc_x);
  assign total_x  = {{TICKET_W{1'b0}}, total_q};
  assign winner_x = {{WINNER_W{1'b0}}, res_winner_q};

  // Next state and datapath control.
  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    total_d      = total_q;
    acc_d        = acc_q;
    idx_d        = idx_q;
    res_status_d = res_status_q;
    res_winner_d = res_winner_q;
    rd_addr      = idx_q;
    mem_we       = 1'b0;
    out_load     = 1'b0;
    case (state_q)
      S_IDLE: begin
        // Issue the weight read for a remove as the item arrives.
        rd_addr = in_idx;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_status_d = ST_OK;
        res_winner_d = '0;
        state_d      = S_DONE;
        case (func_q)
          FUNC_ADD: begin
            if (!in_range_q || valid_q[slot_q]) begin
              res_status_d = ST_BUSY;
            end else begin
              mem_we          = 1'b1;
              valid_d[slot_q] = 1'b1;
              total_d         = total_q + TW'(w_q);
            end
          end
          FUNC_REMOVE: begin
            if (!in_range_q || !valid_q[slot_q]) begin
              res_status_d = ST_EMPTY;
            end else begin
              valid_d[slot_q] = 1'b0;
              total_d         = total_q - TW'(rd_data_q);
            end
          end
          FUNC_PICK: begin
            rd_addr = '0;
            idx_d   = '0;
            acc_d   = '0;
            state_d = S_WALK;
          end
          default: begin
            // Unused operation: no change, plain status.
          end
        endcase
      end
      S_WALK: begin
        // rd_data_q holds the weight of slot idx_q; prefetch the next one.
        rd_addr = idx_q + SW'(1);
        if (valid_q[idx_q]) begin
          acc_d = acc_sum;
        end
        if (hit) begin
          res_status_d = ST_OK;
          res_winner_d = idx_q;
          state_d      = S_DONE;
        end else if (idx_q == LAST) begin
          res_status_d = ST_NOWIN;
          res_winner_d = '0;
          state_d      = S_DONE;
        end else begin
          idx_d = idx_q + SW'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      total_q <= total_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    acc_q        <= acc_d;
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_winner_q <= res_winner_d;
    if (in_accept) begin
      func_q     <= func_i;
      slot_q     <= in_idx;
      in_range_q <= in_range;
      w_q        <= in_weight;
      ticket_q   <= ticket_i;
    end
    if (out_load) begin
      status_q    <= res_status_q;
      winner_q    <= winner_x[WINNER_W-1:0];
      total_out_q <= (total_x > TOTAL_MAX) ? '1 : total_x[TOTAL_W-1:0];
    end
  end

  // Weight memory. Only one item is in work, so a write never meets a read
  // of the same entry in flight.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[slot_q] <= w_q;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign winner_o    = winner_q;
  assign total_out_o = total_out_q;

  // A remove that misses leaves the total alone.
  logic rm_miss;
  assign rm_miss = (func_i == FUNC_REMOVE) && (!in_range || !valid_q[in_idx]);

  a_rm_miss_total : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && rm_miss) |=> ##1 (total_q == $past(total_q, 2)))
    else $error("remove of an empty slot changed the total");

  a_done_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> (state_q == S_IDLE && out_valid_q))
    else $error("finished item not moved into the output register");

  a_walk_total : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |=> (total_q == $past(total_q)))
    else $error("total changed during a pick");

endmodule

[dv/lat_checker.sv]
`timescale 1ns / 1ps
// Checker for the lottery arbiter table: keeps its own copy of the slot table,
// predicts the result of every accepted item and compares the block's results.
// Depends on lat_pkg.
module lat_checker
  import lat_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [SLOT_W-1:0]   slot_i,
  input  logic [PRIO_W-1:0]   priority_req_i,
  input  logic                io_bound_i,
  input  logic [TICKET_W-1:0] ticket_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [STATUS_W-1:0] status_i,
  input  logic [WINNER_W-1:0] winner_i,
  input  logic [TOTAL_W-1:0]  total_out_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam int TOTAL_MAX = (1 << TOTAL_W) - 1;

  typedef struct packed {
    status_e             status;
    logic [WINNER_W-1:0] winner;
    logic [TOTAL_W-1:0]  total;
  } arb_result_t;

  logic              table_valid  [SLOTS_DEF];
  logic [PRIO_W-1:0] table_weight [SLOTS_DEF];
  int unsigned       weight_sum;
  arb_result_t       expected_results[$];
  int                mismatches = 0;

  task automatic report(input string what, input int seen, input int want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, seen, want);
    mismatches++;
  endtask

  // Applies one item to the table copy and returns the result it should give.
  function automatic arb_result_t arbitrate(input logic [FUNC_W-1:0]   op,
                                            input logic [SLOT_W-1:0]   s,
                                            input logic [PRIO_W-1:0]   prio,
                                            input logic                io,
                                            input logic [TICKET_W-1:0] ticket);
    arb_result_t       r;
    int unsigned       acc;
    logic [PRIO_W-1:0] w;
    int                i;
    r.status = ST_OK;
    r.winner = '0;
    acc      = 0;
    case (op)
      FUNC_ADD: begin
        if (table_valid[s]) begin
          r.status = ST_BUSY;
        end else begin
          w               = io ? (prio >> 1) : prio;
          table_valid[s]  = 1'b1;
          table_weight[s] = w;
          weight_sum      += w;
        end
      end
      FUNC_REMOVE: begin
        if (!table_valid[s]) begin
          r.status = ST_EMPTY;
        end else begin
          table_valid[s] = 1'b0;
          weight_sum     -= table_weight[s];
        end
      end
      FUNC_PICK: begin
        r.status = ST_NOWIN;
        for (i = 0; i < SLOTS_DEF; i++) begin
          if (table_valid[i] && r.status == ST_NOWIN) begin
            acc += table_weight[i];
            if (ticket < acc) begin
              r.status = ST_OK;
              r.winner = i[WINNER_W-1:0];
            end
          end
        end
      end
      default: begin
      end
    endcase
    r.total = (weight_sum > TOTAL_MAX) ? TOTAL_W'(TOTAL_MAX) : weight_sum[TOTAL_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    arb_result_t want;
    int          k;
    if (!rst_ni) begin
      for (k = 0; k < SLOTS_DEF; k++) begin
        table_valid[k] = 1'b0;
      end
      weight_sum = 0;
      expected_results.delete();
    end else begin
      // The result side is checked first, so a spurious result cannot be
      // matched against an item accepted at the same edge.
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report("result with no item pending (status)", status_i, -1);
        end else begin
          want = expected_results.pop_front();
          if (status_i != want.status) report("status", status_i, want.status);
          if (winner_i != want.winner) report("winner", winner_i, want.winner);
          if (total_out_i != want.total) report("total", total_out_i, want.total);
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(arbitrate(func_i, slot_i, priority_req_i,
                                             io_bound_i, ticket_i));
      end
    end
    pending_o    = expected_results.size();
    fail_count_o = mismatches;
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// Top of the lottery arbiter table testbench: clock, reset, stimulus and the
// final verdict. Depends on lat_pkg, lottery_arbiter_table and lat_checker.
module tb;
  import lat_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 4;
  localparam int RANDOM_ITEMS = 1450;
  localparam int EPISODE_LEN  = 40;
  // Percent of cycles in which either side idles.
  localparam int IDLE_PCT     = 34;
  // Length of the long receiver hold-off, in cycles.
  localparam int HOLD_CYCLES  = 300;
  // A comfortable margin on the longest item, a pick that walks every slot.
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;

  // The fourth operation code is unused by the block; it must answer harmlessly.
  localparam logic [FUNC_W-1:0]   FUNC_SPARE = 2'd3;
  localparam logic [PRIO_W-1:0]   PRIO_MAX   = '1;
  localparam logic [TICKET_W-1:0] TICKET_MAX = '1;
  localparam logic [SLOT_W-1:0]   SLOT_LAST  = '1;

  // Random traffic comes in episodes, each leaning the table a different way.
  typedef enum int {
    TRAFFIC_FILL,
    TRAFFIC_DRAIN,
    TRAFFIC_MIX
  } traffic_e;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [FUNC_W-1:0]   func;
  logic [SLOT_W-1:0]   slot;
  logic [PRIO_W-1:0]   prio_req;
  logic                io_bound;
  logic [TICKET_W-1:0] ticket;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] status;
  logic [WINNER_W-1:0] winner;
  logic [TOTAL_W-1:0]  total_out;

  int   fails;
  int   pending;
  int   cycles = 0;
  int   random_done = 0;
  // When calm is set, neither side idles.
  logic calm = 1'b0;
  // Counts the long hold-offs the stimulus has asked the receiver for.
  int   hold_reqs = 0;

  lottery_arbiter_table uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .func_i         (func),
    .slot_i         (slot),
    .priority_req_i (prio_req),
    .io_bound_i     (io_bound),
    .ticket_i       (ticket),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .winner_o       (winner),
    .total_out_o    (total_out)
  );

  lat_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .func_i         (func),
    .slot_i         (slot),
    .priority_req_i (prio_req),
    .io_bound_i     (io_bound),
    .ticket_i       (ticket),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .status_i       (status),
    .winner_i       (winner),
    .total_out_i    (total_out),
    .fail_count_o   (fails),
    .pending_o      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offers one item. Valid stays high from the previous item unless an idle
  // cycle is inserted, so back-to-back items never drop valid. Inputs change
  // only at the falling edge; the acceptance is seen at the rising edge, where
  // in_ready still holds its value from before the edge.
  task automatic send_item(input logic [FUNC_W-1:0]   f,
                           input logic [SLOT_W-1:0]   s,
                           input logic [PRIO_W-1:0]   p,
                           input logic                io,
                           input logic [TICKET_W-1:0] t);
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    func     <= f;
    slot     <= s;
    prio_req <= p;
    io_bound <= io;
    ticket   <= t;
    do @(posedge clk); while (!in_ready);
  endtask

  // One random item. Tickets are drawn at several scales so that they land
  // inside the typical total as well as far beyond it.
  task automatic random_item(input traffic_e mode);
    int                  roll;
    logic [FUNC_W-1:0]   f;
    logic [PRIO_W-1:0]   p;
    logic                io;
    logic [TICKET_W-1:0] t;
    roll = $urandom_range(0, 99);
    p    = PRIO_W'($urandom_range(0, PRIO_MAX));
    io   = 1'($urandom_range(0, 1));
    t    = TICKET_W'($urandom_range(0, TICKET_MAX) >> $urandom_range(0, 4));
    case (mode)
      TRAFFIC_FILL: begin
        // Heavy clients pushed in, so the total climbs toward its maximum.
        if (roll < 55) begin
          f  = FUNC_ADD;
          p  = PRIO_W'($urandom_range(PRIO_MAX / 2, PRIO_MAX));
          io = ($urandom_range(0, 9) == 0);
        end else if (roll < 90) begin
          f = FUNC_PICK;
        end else if (roll < 96) begin
          f = FUNC_REMOVE;
        end else begin
          f = FUNC_SPARE;
        end
      end
      TRAFFIC_DRAIN: begin
        if (roll < 50) f = FUNC_REMOVE;
        else if (roll < 85) f = FUNC_PICK;
        else if (roll < 97) f = FUNC_ADD;
        else f = FUNC_SPARE;
      end
      default: begin
        if (roll < 35) f = FUNC_ADD;
        else if (roll < 60) f = FUNC_REMOVE;
        else if (roll < 95) f = FUNC_PICK;
        else f = FUNC_SPARE;
      end
    endcase
    send_item(f, SLOT_W'($urandom_range(0, SLOT_LAST)), p, io, t);
    random_done++;
  endtask

  // Result side. It idles at random, except in the calm stretch, and on
  // request holds off for a long run of cycles while the sender keeps
  // offering items, so the block fills and must stall its input.
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin : stimulus
    int ep;
    in_valid = 1'b0;
    func     = FUNC_ADD;
    slot     = '0;
    prio_req = '0;
    io_bound = 1'b0;
    ticket   = '0;
    rst_n    = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // Directed part. An empty table must give no winner and refuse a remove.
    send_item(FUNC_PICK,   4'd0,      8'd0,     1'b0, 12'd0);
    send_item(FUNC_REMOVE, 4'd3,      8'd0,     1'b0, 12'd0);
    // A zero-weight client in slot 0, a full-weight client in the last slot,
    // and an I/O-bound client with an odd priority, whose half rounds down.
    send_item(FUNC_ADD,    4'd0,      8'd0,     1'b0, 12'd0);
    send_item(FUNC_ADD,    SLOT_LAST, PRIO_MAX, 1'b0, 12'd0);
    send_item(FUNC_ADD,    4'd7,      PRIO_MAX, 1'b1, TICKET_MAX);
    // Adding to a taken slot is refused and leaves the weight alone.
    send_item(FUNC_ADD,    4'd7,      8'd10,    1'b0, 12'd0);
    // Priority one halved gives another zero-weight slot ahead of the others.
    send_item(FUNC_ADD,    4'd1,      8'd1,     1'b1, 12'd0);
    // Walk the range boundaries: zero-weight slots never win, slot 7 holds
    // [0, 127) and the last slot holds [127, 382).
    send_item(FUNC_PICK,   4'd0,      8'd0,     1'b0, 12'd0);
    send_item(FUNC_PICK,   4'd0,      8'd0,     1'b0, 12'd126);
    send_item(FUNC_PICK,   4'd0,      8'd0,     1'b0, 12'd127);
    send_item(FUNC_PICK,   4'd0,      8'd0,     1'b0, 12'd381);
    send_item(FUNC_PICK,   4'd0,      8'd0,     1'b0, 12'd382);
    send_item(FUNC_PICK,   SLOT_LAST, PRIO_MAX, 1'b1, TICKET_MAX);
    // The unused code changes nothing and reports the current total.
    send_item(FUNC_SPARE,  4'd5,      PRIO_MAX, 1'b1, TICKET_MAX);
    send_item(FUNC_REMOVE, 4'd7,      8'd0,     1'b0, 12'd0);
    send_item(FUNC_PICK,   4'd0,      8'd0,     1'b0, 12'd0);
    send_item(FUNC_REMOVE, 4'd0,      8'd0,     1'b0, 12'd0);
    send_item(FUNC_REMOVE, 4'd0,      8'd0,     1'b0, 12'd0);
    send_item(FUNC_ADD,    4'd0,      8'd200,   1'b0, 12'd0);
    send_item(FUNC_PICK,   4'd0,      8'd0,     1'b0, 12'd199);
    send_item(FUNC_PICK,   4'd0,      8'd0,     1'b0, 12'd200);
    send_item(FUNC_REMOVE, SLOT_LAST, 8'd0,     1'b0, 12'd0);
    send_item(FUNC_REMOVE, 4'd1,      8'd0,     1'b0, 12'd0);

    // Random part, in episodes. A few episodes run with no idling at all,
    // and two episodes start with a long hold-off on the result side.
    ep = 0;
    while (random_done < RANDOM_ITEMS) begin
      calm = (ep >= 12 && ep < 16);
      if (ep == 2 || ep == 20) hold_reqs++;
      repeat (EPISODE_LEN) random_item(traffic_e'($urandom_range(0, 2)));
      ep++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
